FILE: sv/tlsf_pkg.sv
`default_nettype none
package tlsf_pkg;

	localparam int MAX_BLOCKS  = 256;
	localparam int HW          = 8;
	localparam int SZW         = 28;
	localparam int CNTW        = 9;
	localparam int SL_LOG2     = 5;
	localparam int SL_COUNT    = 32;
	localparam int ALIGN_LOG2  = 8;
	localparam int MIN_SIZE    = 256;
	localparam int FL_COUNT    = 20;
	localparam int FLW         = 5;
	localparam int SLW         = 5;
	localparam int BKW         = FLW + SLW;
	localparam int BK_DEPTH    = FL_COUNT * SL_COUNT;
	localparam logic [SZW-1:0] HEAP_RESET = 28'd134217728;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_FIT     = 2'd1;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
	localparam logic [1:0] ST_NO_HEADER  = 2'd3;

	typedef struct packed {
		logic           action;
		logic [SZW-1:0] request_size;
		logic [HW-1:0]  block_handle;
	} in_t;

	typedef struct packed {
		logic [1:0]     status;
		logic [HW-1:0]  handle;
		logic [SZW-1:0] offset;
		logic [SZW-1:0] granted_size;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT,
		S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
		S_U0, S_U1, S_U2,
		S_L0, S_L1, S_L2,
		S_RESP
	} state_t;

	typedef struct packed {
		state_t step;
		logic   accept;
	} cmd_t;

	typedef struct packed {
		logic fail;
		logic split;
		logic merge;
		logic heap_ok;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [FLW-1:0] fl;
		logic [SLW-1:0] sl;
	} map_t;

	function automatic logic [4:0] flog2(input logic [SZW:0] v);
		logic [4:0] l;
		l = '0;
		for (int i = 1; i <= SZW; i++) begin
			if (v[i]) l = 5'(i);
		end
		return l;
	endfunction

	function automatic logic [4:0] low_bit(input logic [31:0] v);
		logic [4:0] r;
		r = 5'd31;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	// size is at least MIN_SIZE; first level comes back unclamped
	function automatic map_t map_size(input logic [SZW:0] size);
		logic [4:0]   l;
		logic [SZW:0] top;
		map_t         m;
		l    = flog2(size);
		top  = size >> (l - 5'(SL_LOG2));
		m.fl = FLW'(l - 5'(ALIGN_LOG2));
		m.sl = top[SLW-1:0];
		return m;
	endfunction

	function automatic map_t map_free(input logic [SZW:0] size);
		map_t m;
		m = map_size(size);
		if (m.fl >= FLW'(FL_COUNT)) begin
			m.fl = FLW'(FL_COUNT - 1);
			m.sl = '1;
		end
		return m;
	endfunction

	function automatic logic [SZW:0] round_size(input logic [SZW-1:0] req);
		logic [SZW:0] s0;
		logic [4:0]   l;
		logic [4:0]   gs;
		logic [SZW:0] mask;
		s0   = (req < SZW'(MIN_SIZE)) ? (SZW+1)'(MIN_SIZE) : {1'b0, req};
		l    = flog2(s0);
		gs   = (l > 5'(SL_LOG2)) ? (l - 5'(SL_LOG2)) : 5'd0;
		mask = ((SZW+1)'(1) << gs) - (SZW+1)'(1);
		return (s0 + mask) & ~mask;
	endfunction

endpackage
`default_nettype wire

FILE: sv/tlsf_block_allocator.sv
// Two-level segregated-fit allocator over one region of heap_size bytes.
// Input channel (in_valid / in_stall / in_data): one beat is one request,
//   allocate (action 0, request_size) or free (action 1, block_handle).
// Output channel (out_valid / out_stall / out_data): exactly one result beat
//   per request, in request order: status, handle, offset, granted_size.
// Configuration: cfg_we with cfg_data writes heap_size and rebuilds the pool
//   as one free block at offset 0, handle 0. Write it only while idle.
// Throughput: one request is in flight at a time. A rejected request answers
//   soonest; an allocate takes longer when it splits, and a free takes
//   longer the more neighbours merge. The bound is the single read and
//   write port on each header and bucket memory, walked by the sequencer
//   one access per cycle.
// Reset: masks, flags and the header stack clear at once; the block then
//   stalls input while it files the root block in S_INIT and S_L0 to S_L2,
//   if heap_size is at least MIN_SIZE. A heap_size write does the same.
// Stall: a beat waits in the output register while out_stall is high; the
//   next result, and then the next request, go in once it is handed over.
`default_nettype none
module tlsf_block_allocator (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  tlsf_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output tlsf_pkg::out_t                out_data,
	input  wire logic                     cfg_we,
	input  wire logic [tlsf_pkg::SZW-1:0] cfg_data
);

	tlsf_pkg::cmd_t cmd;
	tlsf_pkg::sts_t sts;

	// sequencer: walks allocate, free, link and unlink steps
	tlsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.cfg_we    (cfg_we),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	// memories, masks, flags and the output register
	tlsf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

FILE: sv/tlsf_ctrl.sv
`default_nettype none
module tlsf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_action,
	input  wire logic             cfg_we,
	input  tlsf_pkg::sts_t        sts,
	output tlsf_pkg::cmd_t        cmd,
	output logic                  in_stall
);

	tlsf_pkg::state_t state_q, state_d;
	tlsf_pkg::state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlsf_pkg::S_INIT;
			ret_q   <= tlsf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		in_stall   = (state_q != tlsf_pkg::S_IDLE);
		cmd.step   = state_q;
		cmd.accept = in_valid && (state_q == tlsf_pkg::S_IDLE);
		case (state_q)
			tlsf_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (in_action == tlsf_pkg::ACT_FREE) ? tlsf_pkg::S_F0 : tlsf_pkg::S_A0;
				end
			end
			tlsf_pkg::S_INIT: begin
				if (sts.heap_ok) begin
					state_d = tlsf_pkg::S_L0;
					ret_d   = tlsf_pkg::S_IDLE;
				end else begin
					state_d = tlsf_pkg::S_IDLE;
				end
			end
			tlsf_pkg::S_A0: state_d = tlsf_pkg::S_A1;
			tlsf_pkg::S_A1: state_d = sts.fail ? tlsf_pkg::S_RESP : tlsf_pkg::S_A2;
			tlsf_pkg::S_A2: state_d = sts.fail ? tlsf_pkg::S_RESP : tlsf_pkg::S_A3;
			tlsf_pkg::S_A3: state_d = tlsf_pkg::S_A4;
			tlsf_pkg::S_A4: state_d = tlsf_pkg::S_A5;
			tlsf_pkg::S_A5: begin
				if (sts.fail) begin
					state_d = tlsf_pkg::S_RESP;
				end else begin
					state_d = tlsf_pkg::S_U0;
					ret_d   = tlsf_pkg::S_A6;
				end
			end
			tlsf_pkg::S_A6: state_d = sts.split ? tlsf_pkg::S_A7 : tlsf_pkg::S_RESP;
			tlsf_pkg::S_A7: begin
				state_d = tlsf_pkg::S_L0;
				ret_d   = tlsf_pkg::S_RESP;
			end
			tlsf_pkg::S_F0: state_d = sts.fail ? tlsf_pkg::S_RESP : tlsf_pkg::S_F1;
			tlsf_pkg::S_F1: state_d = tlsf_pkg::S_F2;
			tlsf_pkg::S_F2: begin
				if (sts.merge) begin
					state_d = tlsf_pkg::S_U0;
					ret_d   = tlsf_pkg::S_F3;
				end else begin
					state_d = tlsf_pkg::S_F4;
				end
			end
			tlsf_pkg::S_F3: state_d = tlsf_pkg::S_F4;
			tlsf_pkg::S_F4: state_d = tlsf_pkg::S_F5;
			tlsf_pkg::S_F5: state_d = tlsf_pkg::S_F6;
			tlsf_pkg::S_F6: begin
				if (sts.merge) begin
					state_d = tlsf_pkg::S_U0;
					ret_d   = tlsf_pkg::S_F7;
				end else begin
					state_d = tlsf_pkg::S_F8;
				end
			end
			tlsf_pkg::S_F7: state_d = tlsf_pkg::S_F8;
			tlsf_pkg::S_F8: begin
				state_d = tlsf_pkg::S_L0;
				ret_d   = tlsf_pkg::S_RESP;
			end
			tlsf_pkg::S_U0: state_d = tlsf_pkg::S_U1;
			tlsf_pkg::S_U1: state_d = tlsf_pkg::S_U2;
			tlsf_pkg::S_U2: state_d = ret_q;
			tlsf_pkg::S_L0: state_d = tlsf_pkg::S_L1;
			tlsf_pkg::S_L1: state_d = tlsf_pkg::S_L2;
			tlsf_pkg::S_L2: state_d = ret_q;
			tlsf_pkg::S_RESP: begin
				if (sts.out_free) state_d = tlsf_pkg::S_IDLE;
			end
			default: state_d = tlsf_pkg::S_IDLE;
		endcase
		// a heap_size write restarts the pool from any state
		if (cfg_we) state_d = tlsf_pkg::S_INIT;
	end

endmodule
`default_nettype wire

FILE: sv/tlsf_dp.sv
`default_nettype none
module tlsf_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  tlsf_pkg::cmd_t                   cmd,
	input  tlsf_pkg::in_t                    in_data,
	input  wire logic                        cfg_we,
	input  wire logic [tlsf_pkg::SZW-1:0]    cfg_data,
	input  wire logic                        out_stall,
	output tlsf_pkg::sts_t                   sts,
	output logic                             out_valid,
	output tlsf_pkg::out_t                   out_data
);

	localparam int HW  = tlsf_pkg::HW;
	localparam int SZW = tlsf_pkg::SZW;
	localparam int NB  = tlsf_pkg::MAX_BLOCKS;
	localparam int FLN = tlsf_pkg::FL_COUNT;

	// header memories
	logic [SZW-1:0] off_mem   [NB];
	logic [SZW-1:0] size_mem  [NB];
	logic [HW-1:0]  nphys_mem [NB];
	logic [HW-1:0]  pphys_mem [NB];
	logic [HW-1:0]  nfree_mem [NB];
	logic [HW-1:0]  pfree_mem [NB];
	logic [HW-1:0]  stk_mem   [NB];
	logic [HW-1:0]  bkt_mem   [tlsf_pkg::BK_DEPTH];

	logic [SZW-1:0] off_rd, size_rd;
	logic [HW-1:0]  nphys_rd, pphys_rd, nfree_rd, pfree_rd, stk_rd, bkt_rd;

	logic               off_we, size_we, nphys_we, pphys_we, nfree_we, pfree_we, bkt_we, stk_we;
	logic [HW-1:0]      off_wa, size_wa, nphys_wa, pphys_wa, nfree_wa, pfree_wa, stk_wa;
	logic [SZW-1:0]     off_wd, size_wd;
	logic [HW-1:0]      nphys_wd, pphys_wd, nfree_wd, pfree_wd, bkt_wd, stk_wd;
	logic [tlsf_pkg::BKW-1:0] bkt_wa, bkt_ra;
	logic [HW-1:0]      ha, stk_ra;

	// control state
	logic [SZW-1:0]     heap_q;
	logic [NB-1:0]      live_q, free_q, pok_q, nok_q;
	logic [FLN-1:0]     flm_q;
	logic [31:0]        slm_q [FLN];
	logic [tlsf_pkg::CNTW-1:0] cnt_q, min_q, cnt_dec;
	logic               out_valid_q;

	// working registers
	tlsf_pkg::in_t      req_q;
	tlsf_pkg::out_t     res_q, out_q;
	logic [SZW:0]       s_q;
	logic [tlsf_pkg::FLW-1:0] fl_q, mfl_q;
	logic [tlsf_pkg::SLW-1:0] sl_q, msl_q;
	logic [31:0]        slb_q;
	logic [HW-1:0]      b_q, p_q, n_q, r_q, tgt_q, pp_q, nn_q, nb_q, nf_q;
	logic [SZW-1:0]     boff_q, bsize_q, offx_q, sizex_q;
	logic               split_q;

	// combinational helpers
	tlsf_pkg::map_t     m_alloc, m_size;
	logic [31:0]        slb0, slb_alt;
	logic [FLN-1:0]     flb;
	logic [4:0]         nfl;
	logic               hv, uhit, a2_fail, a5_split;
	logic [SZW:0]       diff;
	logic [31:0]        cleared;

	assign m_alloc  = tlsf_pkg::map_size(s_q);
	assign m_size   = tlsf_pkg::map_free({1'b0, size_rd});
	assign slb0     = slm_q[fl_q] & (32'hFFFF_FFFF << sl_q);
	assign flb      = flm_q & (~{FLN{1'b0}} << (fl_q + 5'd1));
	assign nfl      = tlsf_pkg::low_bit(32'(flb));
	assign slb_alt  = (nfl < 5'(FLN)) ? slm_q[nfl] : 32'd0;
	assign a2_fail  = (slb0 == 32'd0) &&
		(((fl_q + 5'd1) >= 5'(FLN)) || (flb == '0) || (slb_alt == 32'd0));
	assign diff     = {1'b0, size_rd} - s_q;
	assign a5_split = (diff >= (SZW+1)'(tlsf_pkg::MIN_SIZE));
	assign hv       = slm_q[mfl_q][msl_q];
	assign uhit     = hv && (bkt_rd == tgt_q);
	assign cleared  = slm_q[mfl_q] & ~(32'd1 << msl_q);
	assign cnt_dec  = cnt_q - 9'd1;
	assign stk_ra   = cnt_dec[HW-1:0];

	always_comb begin
		sts.fail     = 1'b0;
		sts.merge    = 1'b0;
		sts.split    = split_q;
		sts.heap_ok  = (heap_q >= SZW'(tlsf_pkg::MIN_SIZE));
		sts.out_free = !out_valid_q || !out_stall;
		case (cmd.step)
			tlsf_pkg::S_A1: sts.fail = (m_alloc.fl >= 5'(FLN));
			tlsf_pkg::S_A2: sts.fail = a2_fail;
			tlsf_pkg::S_A5: sts.fail = ({1'b0, size_rd} < s_q) || (a5_split && (cnt_q == '0));
			tlsf_pkg::S_F0: sts.fail = !(live_q[req_q.block_handle] && !free_q[req_q.block_handle]);
			tlsf_pkg::S_F2: sts.merge = free_q[p_q] && (off_rd < boff_q);
			tlsf_pkg::S_F6: sts.merge = free_q[n_q] && (off_rd > boff_q);
			default: ;
		endcase
	end

	// read addresses
	always_comb begin
		case (cmd.step)
			tlsf_pkg::S_A4: ha = bkt_rd;
			tlsf_pkg::S_F0: ha = req_q.block_handle;
			tlsf_pkg::S_F1: ha = pphys_rd;
			tlsf_pkg::S_F4: ha = b_q;
			tlsf_pkg::S_F5: ha = nphys_rd;
			default:        ha = tgt_q;
		endcase
		case (cmd.step)
			tlsf_pkg::S_U1, tlsf_pkg::S_L1: bkt_ra = {m_size.fl, m_size.sl};
			tlsf_pkg::S_A3:                 bkt_ra = {fl_q, tlsf_pkg::low_bit(slb_q)};
			default:                        bkt_ra = {mfl_q, msl_q};
		endcase
	end

	// write ports
	always_comb begin
		off_we = 1'b0;   off_wa = '0;   off_wd = '0;
		size_we = 1'b0;  size_wa = '0;  size_wd = '0;
		nphys_we = 1'b0; nphys_wa = '0; nphys_wd = '0;
		pphys_we = 1'b0; pphys_wa = '0; pphys_wd = '0;
		nfree_we = 1'b0; nfree_wa = '0; nfree_wd = '0;
		pfree_we = 1'b0; pfree_wa = '0; pfree_wd = '0;
		bkt_we = 1'b0;   bkt_wa = {mfl_q, msl_q}; bkt_wd = '0;
		stk_we = 1'b0;   stk_wa = cnt_q[HW-1:0]; stk_wd = '0;
		case (cmd.step)
			tlsf_pkg::S_INIT: begin
				off_we = 1'b1;   off_wa = '0;   off_wd = '0;
				size_we = 1'b1;  size_wa = '0;  size_wd = heap_q;
				nphys_we = 1'b1; nphys_wa = '0; nphys_wd = '0;
				pphys_we = 1'b1; pphys_wa = '0; pphys_wd = '0;
			end
			tlsf_pkg::S_U1: begin
				nfree_we = pok_q[tgt_q]; nfree_wa = pfree_rd; nfree_wd = nfree_rd;
				pfree_we = nok_q[tgt_q]; pfree_wa = nfree_rd; pfree_wd = pfree_rd;
			end
			tlsf_pkg::S_U2: begin
				bkt_we = uhit; bkt_wd = nf_q;
			end
			tlsf_pkg::S_L2: begin
				nfree_we = 1'b1; nfree_wa = tgt_q;  nfree_wd = bkt_rd;
				pfree_we = hv;   pfree_wa = bkt_rd; pfree_wd = tgt_q;
				bkt_we = 1'b1;   bkt_wd = tgt_q;
			end
			tlsf_pkg::S_A6: begin
				nphys_we = split_q; nphys_wa = b_q;    nphys_wd = stk_rd;
				pphys_we = split_q; pphys_wa = stk_rd; pphys_wd = b_q;
				off_we = split_q;   off_wa = stk_rd;   off_wd = boff_q + s_q[SZW-1:0];
				size_we = split_q;  size_wa = stk_rd;  size_wd = bsize_q - s_q[SZW-1:0];
			end
			tlsf_pkg::S_A7: begin
				nphys_we = 1'b1; nphys_wa = r_q;  nphys_wd = nb_q;
				pphys_we = 1'b1; pphys_wa = nb_q; pphys_wd = r_q;
				size_we = 1'b1;  size_wa = b_q;   size_wd = s_q[SZW-1:0];
			end
			tlsf_pkg::S_F3: begin
				off_we = 1'b1;   off_wa = b_q;   off_wd = offx_q;
				size_we = 1'b1;  size_wa = b_q;  size_wd = bsize_q + sizex_q;
				pphys_we = 1'b1; pphys_wa = b_q; pphys_wd = pp_q;
				nphys_we = 1'b1; nphys_wa = pp_q; nphys_wd = b_q;
				stk_we = (cnt_q < 9'(NB)); stk_wd = p_q;
			end
			tlsf_pkg::S_F7: begin
				size_we = 1'b1;  size_wa = b_q;  size_wd = bsize_q + sizex_q;
				nphys_we = 1'b1; nphys_wa = b_q; nphys_wd = nn_q;
				pphys_we = 1'b1; pphys_wa = nn_q; pphys_wd = b_q;
				stk_we = (cnt_q < 9'(NB)); stk_wd = n_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (off_we)   off_mem[off_wa]     <= off_wd;
		if (size_we)  size_mem[size_wa]   <= size_wd;
		if (nphys_we) nphys_mem[nphys_wa] <= nphys_wd;
		if (pphys_we) pphys_mem[pphys_wa] <= pphys_wd;
		if (nfree_we) nfree_mem[nfree_wa] <= nfree_wd;
		if (pfree_we) pfree_mem[pfree_wa] <= pfree_wd;
		if (bkt_we)   bkt_mem[bkt_wa]     <= bkt_wd;
		if (stk_we)   stk_mem[stk_wa]     <= stk_wd;
		off_rd   <= off_mem[ha];
		size_rd  <= size_mem[ha];
		nphys_rd <= nphys_mem[ha];
		pphys_rd <= pphys_mem[ha];
		nfree_rd <= nfree_mem[ha];
		pfree_rd <= pfree_mem[ha];
		bkt_rd   <= bkt_mem[bkt_ra];
		// slots below the low-water mark still hold their initial index
		stk_rd   <= ({1'b0, stk_ra} < min_q) ? (HW'(NB - 1) - stk_ra) : stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q      <= tlsf_pkg::HEAP_RESET;
			live_q      <= '0;
			free_q      <= '0;
			pok_q       <= '0;
			nok_q       <= '0;
			flm_q       <= '0;
			for (int i = 0; i < FLN; i++) slm_q[i] <= '0;
			cnt_q       <= 9'(NB - 1);
			min_q       <= 9'(NB - 1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_q <= cfg_data;
				live_q <= '0;
				free_q <= '0;
				pok_q  <= '0;
				nok_q  <= '0;
				flm_q  <= '0;
				for (int i = 0; i < FLN; i++) slm_q[i] <= '0;
				cnt_q  <= 9'(NB - 1);
				min_q  <= 9'(NB - 1);
			end else begin
				case (cmd.step)
					tlsf_pkg::S_INIT: begin
						if (sts.heap_ok) live_q[0] <= 1'b1;
					end
					tlsf_pkg::S_U1: begin
						if (pok_q[tgt_q]) nok_q[pfree_rd] <= nok_q[tgt_q];
						if (nok_q[tgt_q]) pok_q[nfree_rd] <= pok_q[tgt_q];
						free_q[tgt_q] <= 1'b0;
					end
					tlsf_pkg::S_U2: begin
						if (uhit && !nok_q[tgt_q]) begin
							slm_q[mfl_q] <= cleared;
							if (cleared == 32'd0) flm_q[mfl_q] <= 1'b0;
						end
						pok_q[tgt_q] <= 1'b0;
						nok_q[tgt_q] <= 1'b0;
					end
					tlsf_pkg::S_L2: begin
						free_q[tgt_q] <= 1'b1;
						nok_q[tgt_q]  <= hv;
						pok_q[tgt_q]  <= 1'b0;
						if (hv) pok_q[bkt_rd] <= 1'b1;
						slm_q[mfl_q][msl_q] <= 1'b1;
						flm_q[mfl_q] <= 1'b1;
					end
					tlsf_pkg::S_A6: begin
						if (split_q) begin
							cnt_q <= cnt_dec;
							if (cnt_dec < min_q) min_q <= cnt_dec;
							live_q[stk_rd] <= 1'b1;
							free_q[stk_rd] <= 1'b0;
							pok_q[stk_rd]  <= 1'b0;
							nok_q[stk_rd]  <= 1'b0;
						end
					end
					tlsf_pkg::S_F3: begin
						live_q[p_q] <= 1'b0;
						free_q[p_q] <= 1'b0;
						if (cnt_q < 9'(NB)) cnt_q <= cnt_q + 9'd1;
					end
					tlsf_pkg::S_F7: begin
						live_q[n_q] <= 1'b0;
						free_q[n_q] <= 1'b0;
						if (cnt_q < 9'(NB)) cnt_q <= cnt_q + 9'd1;
					end
					default: ;
				endcase
			end
			if (cmd.step == tlsf_pkg::S_RESP && sts.out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= in_data;
		case (cmd.step)
			tlsf_pkg::S_INIT: tgt_q <= '0;
			tlsf_pkg::S_A0:   s_q <= tlsf_pkg::round_size(req_q.request_size);
			tlsf_pkg::S_A1: begin
				fl_q  <= m_alloc.fl;
				sl_q  <= m_alloc.sl;
				res_q <= '{tlsf_pkg::ST_NO_FIT, '0, '0, '0};
			end
			tlsf_pkg::S_A2: begin
				if (slb0 != 32'd0) begin
					slb_q <= slb0;
				end else begin
					slb_q <= slb_alt;
					fl_q  <= nfl;
				end
				res_q <= '{tlsf_pkg::ST_NO_FIT, '0, '0, '0};
			end
			tlsf_pkg::S_A4: b_q <= bkt_rd;
			tlsf_pkg::S_A5: begin
				boff_q  <= off_rd;
				bsize_q <= size_rd;
				nb_q    <= nphys_rd;
				split_q <= a5_split;
				tgt_q   <= b_q;
				if ({1'b0, size_rd} < s_q) begin
					res_q <= '{tlsf_pkg::ST_NO_FIT, '0, '0, '0};
				end else begin
					res_q <= '{tlsf_pkg::ST_NO_HEADER, '0, '0, '0};
				end
			end
			tlsf_pkg::S_A6: begin
				r_q   <= stk_rd;
				res_q <= '{tlsf_pkg::ST_OK, b_q, boff_q, split_q ? s_q[SZW-1:0] : bsize_q};
			end
			tlsf_pkg::S_A7: tgt_q <= r_q;
			tlsf_pkg::S_F0: begin
				b_q   <= req_q.block_handle;
				res_q <= '{tlsf_pkg::ST_BAD_HANDLE, req_q.block_handle, '0, '0};
			end
			tlsf_pkg::S_F1: begin
				p_q     <= pphys_rd;
				boff_q  <= off_rd;
				bsize_q <= size_rd;
			end
			tlsf_pkg::S_F2: begin
				offx_q  <= off_rd;
				sizex_q <= size_rd;
				pp_q    <= pphys_rd;
				tgt_q   <= p_q;
			end
			tlsf_pkg::S_F3: begin
				boff_q  <= offx_q;
				bsize_q <= bsize_q + sizex_q;
			end
			tlsf_pkg::S_F5: n_q <= nphys_rd;
			tlsf_pkg::S_F6: begin
				sizex_q <= size_rd;
				nn_q    <= nphys_rd;
				tgt_q   <= n_q;
			end
			tlsf_pkg::S_F7: bsize_q <= bsize_q + sizex_q;
			tlsf_pkg::S_F8: begin
				tgt_q <= b_q;
				res_q <= '{tlsf_pkg::ST_OK, b_q, boff_q, bsize_q};
			end
			tlsf_pkg::S_U1: begin
				mfl_q <= m_size.fl;
				msl_q <= m_size.sl;
				nf_q  <= nfree_rd;
			end
			tlsf_pkg::S_L1: begin
				mfl_q <= m_size.fl;
				msl_q <= m_size.sl;
			end
			tlsf_pkg::S_RESP: begin
				if (sts.out_free) out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

FILE: sv/tlsf_chk.sv
`default_nettype none
module tlsf_chk (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_stall,
	input tlsf_pkg::in_t                 in_data,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input tlsf_pkg::out_t                out_data,
	input wire logic                     cfg_we,
	input wire logic [tlsf_pkg::SZW-1:0] cfg_data
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// rebuild the pool after a heap_size write
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input open during pool rebuild");

	// failed results carry no block
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != tlsf_pkg::ST_OK |->
		out_data.offset == '0 && out_data.granted_size == '0)
		else $error("failed result carries a block");

	// granted blocks are never below the minimum size
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == tlsf_pkg::ST_OK |->
		out_data.granted_size >= tlsf_pkg::SZW'(tlsf_pkg::MIN_SIZE))
		else $error("granted block below minimum size");

endmodule

bind tlsf_block_allocator tlsf_chk u_chk (.*);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

import tlsf_pkg::*;

// Mirrors the allocator state and queues the result of every accepted request.
class alloc_scoreboard;
	bit [SZW-1:0] heap;
	bit [31:0]    fl_bits;
	bit [31:0]    sl_bits [FL_COUNT];
	bit [7:0]     head    [FL_COUNT][SL_COUNT];
	bit           head_ok [FL_COUNT][SL_COUNT];
	bit [SZW-1:0] offs    [MAX_BLOCKS];
	bit [SZW-1:0] sizes   [MAX_BLOCKS];
	bit [7:0]     pfree   [MAX_BLOCKS];
	bit [7:0]     nfree   [MAX_BLOCKS];
	bit           pfree_ok[MAX_BLOCKS];
	bit           nfree_ok[MAX_BLOCKS];
	bit [7:0]     pphys   [MAX_BLOCKS];
	bit [7:0]     nphys   [MAX_BLOCKS];
	bit           is_free [MAX_BLOCKS];
	bit           is_live [MAX_BLOCKS];
	bit [7:0]     spare   [MAX_BLOCKS];
	int           spare_n;
	out_t         awaited[$];
	bit [7:0]     held[$];

	function int flog(longint unsigned v);
		int l;
		l = 0;
		while (v > 1) begin
			v = v >> 1;
			l++;
		end
		return l;
	endfunction

	function int lowest(bit [31:0] v);
		int i;
		i = 0;
		while (i < 31 && !v[i]) i++;
		return i;
	endfunction

	function void bucket_of(longint unsigned sz, output int fl, output int sl);
		int l;
		longint unsigned top;
		l = flog(sz);
		top = sz >> (l - SL_LOG2);
		sl = int'((top ^ SL_COUNT) & (SL_COUNT - 1));
		fl = l - ALIGN_LOG2;
	endfunction

	function void free_bucket(bit [SZW-1:0] sz, output int fl, output int sl);
		bucket_of(sz, fl, sl);
		if (fl >= FL_COUNT) begin
			fl = FL_COUNT - 1;
			sl = SL_COUNT - 1;
		end
	endfunction

	function void file_block(bit [7:0] b);
		int fl, sl;
		free_bucket(sizes[b], fl, sl);
		is_free[b] = 1;
		pfree_ok[b] = 0;
		nfree_ok[b] = head_ok[fl][sl];
		nfree[b] = head[fl][sl];
		if (head_ok[fl][sl]) begin
			pfree[head[fl][sl]] = b;
			pfree_ok[head[fl][sl]] = 1;
		end
		head[fl][sl] = b;
		head_ok[fl][sl] = 1;
		fl_bits[fl] = 1;
		sl_bits[fl][sl] = 1;
	endfunction

	function void pull_block(bit [7:0] b);
		int fl, sl;
		free_bucket(sizes[b], fl, sl);
		if (pfree_ok[b]) begin
			nfree[pfree[b]] = nfree[b];
			nfree_ok[pfree[b]] = nfree_ok[b];
		end
		if (nfree_ok[b]) begin
			pfree[nfree[b]] = pfree[b];
			pfree_ok[nfree[b]] = pfree_ok[b];
		end
		is_free[b] = 0;
		if (head_ok[fl][sl] && head[fl][sl] == b) begin
			head[fl][sl] = nfree[b];
			head_ok[fl][sl] = nfree_ok[b];
			if (!nfree_ok[b]) begin
				sl_bits[fl][sl] = 0;
				if (sl_bits[fl] == 0) fl_bits[fl] = 0;
			end
		end
		pfree_ok[b] = 0;
		nfree_ok[b] = 0;
	endfunction

	function void configure(bit [SZW-1:0] v);
		heap = v;
		fl_bits = 0;
		for (int i = 0; i < FL_COUNT; i++) begin
			sl_bits[i] = 0;
			for (int j = 0; j < SL_COUNT; j++) begin
				head[i][j] = 0;
				head_ok[i][j] = 0;
			end
		end
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			offs[i] = 0; sizes[i] = 0; pfree[i] = 0; nfree[i] = 0;
			pfree_ok[i] = 0; nfree_ok[i] = 0;
			pphys[i] = 8'(i); nphys[i] = 8'(i);
			is_free[i] = 0; is_live[i] = 0;
		end
		spare_n = MAX_BLOCKS - 1;
		for (int i = 0; i < spare_n; i++) spare[i] = 8'(MAX_BLOCKS - 1 - i);
		sizes[0] = heap;
		held.delete();
		if (heap >= MIN_SIZE) begin
			is_live[0] = 1;
			file_block(0);
		end
	endfunction

	function out_t grant(bit [SZW-1:0] req);
		out_t r;
		longint unsigned s, g;
		int l, gs, fl, sl;
		bit [31:0] slb, flb;
		bit [7:0] b, nb;
		bit split;
		r = '0;
		r.status = ST_NO_FIT;
		s = (req < MIN_SIZE) ? MIN_SIZE : req;
		l = flog(s);
		gs = (l > SL_LOG2) ? l - SL_LOG2 : 0;
		g = longint'(1) << gs;
		s = (s + g - 1) & ~(g - 1);
		bucket_of(s, fl, sl);
		if (fl >= FL_COUNT) return r;
		slb = sl_bits[fl] & (32'hFFFF_FFFF << sl);
		if (slb == 0) begin
			if (fl + 1 >= FL_COUNT) return r;
			flb = fl_bits & (32'hFFFF_FFFF << (fl + 1));
			if (flb == 0) return r;
			fl = lowest(flb);
			slb = sl_bits[fl];
			if (slb == 0) return r;
		end
		sl = lowest(slb);
		if (!head_ok[fl][sl]) return r;
		b = head[fl][sl];
		if (sizes[b] < s) return r;
		split = (sizes[b] - s) >= MIN_SIZE;
		if (split && spare_n == 0) begin
			r.status = ST_NO_HEADER;
			return r;
		end
		pull_block(b);
		if (split) begin
			spare_n--;
			nb = spare[spare_n];
			offs[nb] = SZW'(offs[b] + s);
			sizes[nb] = SZW'(sizes[b] - s);
			sizes[b] = SZW'(s);
			pphys[nb] = b;
			nphys[nb] = nphys[b];
			nphys[b] = nb;
			pphys[nphys[nb]] = nb;
			is_live[nb] = 1;
			is_free[nb] = 0;
			pfree_ok[nb] = 0;
			nfree_ok[nb] = 0;
			file_block(nb);
		end
		held.push_back(b);
		r.status = ST_OK;
		r.handle = b;
		r.offset = offs[b];
		r.granted_size = sizes[b];
		return r;
	endfunction

	function void retire(bit [7:0] p);
		is_live[p] = 0;
		is_free[p] = 0;
		if (spare_n < MAX_BLOCKS) begin
			spare[spare_n] = p;
			spare_n++;
		end
	endfunction

	function out_t release_block(bit [7:0] b);
		out_t r;
		bit [7:0] p, n;
		int idx[$];
		r = '0;
		if (!is_live[b] || is_free[b]) begin
			r.status = ST_BAD_HANDLE;
			r.handle = b;
			return r;
		end
		p = pphys[b];
		if (is_free[p] && offs[p] < offs[b]) begin
			pull_block(p);
			offs[b] = offs[p];
			sizes[b] = sizes[b] + sizes[p];
			pphys[b] = pphys[p];
			nphys[pphys[b]] = b;
			retire(p);
		end
		n = nphys[b];
		if (is_free[n] && offs[n] > offs[b]) begin
			pull_block(n);
			sizes[b] = sizes[b] + sizes[n];
			nphys[b] = nphys[n];
			pphys[nphys[b]] = b;
			retire(n);
		end
		file_block(b);
		idx = held.find_first_index(x) with (x == b);
		if (idx.size() > 0) held.delete(idx[0]);
		r.status = ST_OK;
		r.handle = b;
		r.offset = offs[b];
		r.granted_size = sizes[b];
		return r;
	endfunction

	function void note_request(in_t req);
		if (req.action == ACT_ALLOC) awaited.push_back(grant(req.request_size));
		else awaited.push_back(release_block(req.block_handle));
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	// Returns the number of mismatching fields; msg describes each of them.
	function int check_result(out_t got, output string msg);
		out_t want;
		int bad;
		bad = 0;
		msg = "";
		if (awaited.size() == 0) begin
			msg = $sformatf("result beat with nothing awaited: %p", got);
			return 1;
		end
		want = awaited.pop_front();
		if (got.status != want.status) begin
			bad++;
			msg = $sformatf("status %0d, want %0d", got.status, want.status);
		end
		if (got.handle != want.handle) begin
			bad++;
			msg = {msg, $sformatf(" handle %0d, want %0d", got.handle, want.handle)};
		end
		if (got.offset != want.offset) begin
			bad++;
			msg = {msg, $sformatf(" offset %0h, want %0h", got.offset, want.offset)};
		end
		if (got.granted_size != want.granted_size) begin
			bad++;
			msg = {msg, $sformatf(" size %0h, want %0h", got.granted_size,
				want.granted_size)};
		end
		return bad;
	endfunction
endclass

module tb_top;
	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	in_t            in_data;
	logic           out_valid;
	logic           out_stall;
	out_t           out_data;
	logic           cfg_we;
	logic [SZW-1:0] cfg_data;

	alloc_scoreboard sb;
	int errors;
	int results_seen;
	bit send_burst;
	bit drain_burst;
	int sent_count;

	tlsf_block_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Print a bounded number of lines, but count every mismatch.
	task automatic report(input string msg);
		errors++;
		if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// Offer one request beat after a random gap and hold it until taken.
	// Valid stays high on return; the caller's next beat or drop_valid follows.
	task automatic send(input in_t item);
		int gap;
		if (sent_count % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		sb.note_request(item);
		sent_count++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic alloc(input logic [SZW-1:0] sz);
		in_t it;
		it = '0;
		it.action = ACT_ALLOC;
		it.request_size = sz;
		it.block_handle = 8'($urandom);
		send(it);
	endtask

	task automatic release_handle(input logic [HW-1:0] h);
		in_t it;
		it = '0;
		it.action = ACT_FREE;
		it.block_handle = h;
		it.request_size = SZW'($urandom);
		send(it);
	endtask

	// Wait for the block to drain, then rewrite heap_size.
	task automatic set_heap(input logic [SZW-1:0] v);
		drop_valid();
		while (sb.pending() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(v);
	endtask

	task automatic random_requests(input int n);
		int pick;
		logic [SZW-1:0] sz;
		for (int i = 0; i < n; i++) begin
			if (sb.held.size() != 0 && $urandom_range(0, 99) < 48) begin
				if ($urandom_range(0, 99) < 85)
					release_handle(sb.held[$urandom_range(0, sb.held.size() - 1)]);
				else
					release_handle(8'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 65) sz = SZW'($urandom_range(0, 4096));
				else if (pick < 85) sz = SZW'($urandom_range(0, sb.heap >> 3));
				else if (pick < 97) sz = SZW'($urandom_range(0, sb.heap));
				else sz = SZW'($urandom);
				alloc(sz);
			end
		end
	endtask

	// Use up every header with small grants, then release them in random order.
	task automatic exhaust_headers();
		bit [7:0] order[$];
		for (int i = 0; i < 270; i++) alloc(SZW'($urandom_range(0, 600)));
		order = sb.held;
		order.shuffle();
		foreach (order[i]) release_handle(order[i]);
	endtask

	// Result side: random stall, one long hold-off to back the block up.
	initial begin
		string msg;
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 40 == 0) drain_burst = ($urandom_range(0, 3) == 0);
			if (results_seen == 150) n = 400;
			else n = drain_burst ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (sb.check_result(out_data, msg) != 0) report(msg);
		end
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		results_seen = 0;
		sent_count = 0;
		sb = new();
		sb.configure(HEAP_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: size extremes, rounding edges, oversized, bad frees.
		alloc('0);
		alloc(SZW'(1));
		alloc(SZW'(255));
		alloc(SZW'(256));
		alloc(SZW'(257));
		alloc(SZW'(12345));
		alloc('1);
		alloc(SZW'(HEAP_RESET));
		alloc(SZW'(1 << 20) + 1);
		release_handle(sb.held[1]);
		release_handle(sb.held[0]);
		release_handle(sb.held[1]);
		release_handle(8'd200);
		release_handle(8'd255);
		release_handle(sb.held[0]);
		release_handle(sb.held[0]);
		release_handle(8'd0);
		alloc(SZW'(HEAP_RESET >> 1) + 1);
		alloc(SZW'(HEAP_RESET >> 1));
		release_handle(sb.held[0]);

		random_requests(600);

		set_heap('1);
		exhaust_headers();
		random_requests(200);

		// Smallest usable heap, then heaps too small to hold any block.
		set_heap(SZW'(MIN_SIZE));
		random_requests(30);
		alloc('0);
		set_heap(SZW'(MIN_SIZE - 1));
		alloc('0);
		random_requests(15);
		set_heap('0);
		random_requests(10);

		for (int p = 0; p < 3; p++) begin
			set_heap(SZW'($urandom_range(1 << 14, 1 << 26)));
			random_requests(200);
		end
		drop_valid();

		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

`default_nettype wire
